FILE: sv/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg: shared types and constants of the page table walker
// Memory geometry, queue sizing, descriptor codes and the queued item format.
// ----------------------------------------------------------------------------
package pwt_pkg;

    localparam int MEM_WORDS         = 4096;
    localparam int AW                = $clog2(MEM_WORDS);
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);

    // Queue depth must be a power of two so the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    localparam logic       CMD_WRITE     = 1'b0;
    localparam logic       CMD_TRANSLATE = 1'b1;

    localparam logic [1:0] KIND_TABLE = 2'b11;
    localparam logic [1:0] KIND_BLOCK = 2'b01;

    localparam logic [1:0] LEVEL_0    = 2'd0;
    localparam logic [1:0] LEVEL_LAST = 2'd3;

    typedef struct packed {
        logic        translate;
        logic [11:0] word_index;
        logic [63:0] word_value;
        logic [47:0] virtual_address;
    } t_item;

    typedef struct packed {
        logic clearing;
    } t_back_status;

    // Table index taken from the virtual address at a given level.
    function automatic logic [IDX_W-1:0] va_index(input logic [47:0] va,
                                                  input logic [1:0] level);
        logic [IDX_W-1:0] idx;
        case (level)
            2'd0:    idx = va[47:39];
            2'd1:    idx = va[38:30];
            2'd2:    idx = va[29:21];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

    // Word address of an entry: (table address[47:12] << 9) + index, wrapped.
    function automatic logic [AW-1:0] entry_addr(input logic [47:0] table_pa,
                                                 input logic [IDX_W-1:0] idx);
        logic [36+IDX_W-1:0] full;
        full = {table_pa[47:12], idx};
        return full[AW-1:0];
    endfunction

endpackage

FILE: sv/pwt_ram.sv
// ----------------------------------------------------------------------------
// pwt_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module pwt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/pwt_front.sv
// ----------------------------------------------------------------------------
// pwt_front: command intake and item queue
// Accepts commands, tags them as write or translate and queues them in order.
// ----------------------------------------------------------------------------
module pwt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_command,
    input  logic [11:0]           i_word_index,
    input  logic [63:0]           i_word_value,
    input  logic [47:0]           i_virtual_address,
    input  pwt_pkg::t_back_status i_status,
    output logic                  o_head_valid,
    output pwt_pkg::t_item        o_head,
    input  logic                  i_pop
);
    import pwt_pkg::*;

    t_item           r_queue [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QW:0]     r_count, n_count;
    logic            push;
    logic            pop;
    t_item           item;

    assign busy = (r_count == (QW+1)'(QUEUE_DEPTH)) || i_status.clearing;
    assign push = start && !busy;
    assign pop  = i_pop && o_head_valid;

    always_comb begin
        item.translate       = (i_command == CMD_TRANSLATE);
        item.word_index      = i_word_index;
        item.word_value      = i_word_value;
        item.virtual_address = i_virtual_address;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item;
        end
    end

    assign o_head_valid = (r_count != '0);
    assign o_head       = r_queue[r_rd_ptr];

endmodule

FILE: sv/pwt_back.sv
// ----------------------------------------------------------------------------
// pwt_back: descriptor memory and table walk sequencer
// Clears the memory after reset, then executes queued writes and walks.
// ----------------------------------------------------------------------------
module pwt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [47:0]           i_root_base,
    input  logic                  i_head_valid,
    input  pwt_pkg::t_item        i_head,
    output logic                  o_pop,
    output pwt_pkg::t_back_status o_status,
    output logic                  o_result_valid,
    output logic [63:0]           o_descriptor
);
    import pwt_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_clr_cnt, n_clr_cnt;
    logic [1:0]     r_level, n_level;
    logic [47:0]    r_va, n_va;
    logic           r_out_valid, n_out_valid;
    logic [63:0]    r_out_desc, n_out_desc;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [63:0]    ram_wdata;
    logic [63:0]    ram_rdata;
    logic [AW+11:0] widx_ext;
    logic [1:0]     kind;
    logic [1:0]     next_level;

    pwt_ram #(
        .WIDTH(64),
        .DEPTH(MEM_WORDS)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign widx_ext   = {{AW{1'b0}}, i_head.word_index};
    assign kind       = ram_rdata[1:0];
    assign next_level = r_level + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_level     = r_level;
        n_va        = r_va;
        n_out_valid = 1'b0;
        n_out_desc  = r_out_desc;
        ram_we      = 1'b0;
        ram_addr    = r_clr_cnt;
        ram_wdata   = '0;
        o_pop       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == AW'(MEM_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head_valid) begin
                    o_pop = 1'b1;
                    if (i_head.translate) begin
                        ram_addr = entry_addr(i_root_base,
                                              va_index(i_head.virtual_address, LEVEL_0));
                        n_va     = i_head.virtual_address;
                        n_level  = LEVEL_0;
                        n_state  = ST_WALK;
                    end else begin
                        ram_we    = 1'b1;
                        ram_addr  = widx_ext[AW-1:0];
                        ram_wdata = i_head.word_value;
                    end
                end
            end
            ST_WALK: begin
                // Read data of the current level is on the RAM output now.
                ram_addr = entry_addr(ram_rdata[47:0], va_index(r_va, next_level));
                if (r_level == LEVEL_LAST) begin
                    n_out_valid = 1'b1;
                    n_out_desc  = (kind == KIND_TABLE) ? ram_rdata : '0;
                    n_state     = ST_IDLE;
                end else if (kind == KIND_TABLE) begin
                    n_level = next_level;
                end else begin
                    // Block entries are legal only at the middle two levels.
                    n_out_valid = 1'b1;
                    n_out_desc  = (kind == KIND_BLOCK && r_level != LEVEL_0)
                                  ? ram_rdata : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_level     <= LEVEL_0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_va       <= n_va;
        r_out_desc <= n_out_desc;
    end

    assign o_status.clearing = (r_state == ST_CLEAR);
    assign o_result_valid    = r_out_valid;
    assign o_descriptor      = r_out_desc;

endmodule

FILE: sv/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker: 4 KiB granule, four-level table walker
// Translates 48-bit virtual addresses through tables held in a local memory.
// ----------------------------------------------------------------------------
// Usage: a command is transferred at a rising edge with start high and busy
// low. A write command stores word_value at word_index and gives no result.
// A translate command gives one descriptor, zero on a fault, shown on
// o_descriptor for a single cycle with o_result_valid high.
// The root table base is written through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_data); the user must do so only while the
// block is idle, as the block does not enforce it. Commands pass through a
// two-entry queue to the walk sequencer, so two can be taken while a walk is
// running. A translate holds the sequencer while it issues the root-table
// read and then reads the table levels in turn until a non-table entry or
// the last level, bound by the single-port descriptor memory with its
// registered read; the result strobe follows in the next cycle. A write is
// done as it is issued. After reset all 4096 words (MEM_WORDS) are cleared,
// one word a cycle; busy stays high meanwhile. The receiver cannot stall.
// ----------------------------------------------------------------------------
module four_level_page_table_walker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [11:0] i_word_index,
    input  logic [63:0] i_word_value,
    input  logic [47:0] i_virtual_address,
    output logic        o_result_valid,
    output logic [63:0] o_descriptor,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data
);
    import pwt_pkg::*;

    logic [47:0]  r_root_base;
    logic         head_valid;
    t_item        head;
    logic         pop;
    t_back_status status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_root_base <= i_cfg_data;
        end
    end

    pwt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_word_index     (i_word_index),
        .i_word_value     (i_word_value),
        .i_virtual_address(i_virtual_address),
        .i_status         (status),
        .o_head_valid     (head_valid),
        .o_head           (head),
        .i_pop            (pop)
    );

    pwt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_root_base   (r_root_base),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_status      (status),
        .o_result_valid(o_result_valid),
        .o_descriptor  (o_descriptor)
    );

endmodule

FILE: tb/sv/four_level_page_table_walker_test.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_test: self-checking bench for the table walker
// Builds translation tables through write commands, walks them with translate
// commands and checks every returned descriptor against a local predictor.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_test;
    import pwt_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS  = 170;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_command = CMD_WRITE;
    logic [11:0] i_word_index = '0;
    logic [63:0] i_word_value = '0;
    logic [47:0] i_virtual_address = '0;
    logic        o_result_valid;
    logic [63:0] o_descriptor;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_data = '0;

    // Predictor state: a copy of the descriptor memory and the root base.
    logic [63:0] table_mem [MEM_WORDS];
    logic [47:0] root_base;
    logic [63:0] descriptors_due [$];

    t_item       command_queue [$];
    t_item       next_cmd;
    logic [63:0] want;
    int          sender_idle_pct = 0;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          translations = 0;
    int          hits = 0;
    int          faults = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    four_level_page_table_walker uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_word_index     (i_word_index),
        .i_word_value     (i_word_value),
        .i_virtual_address(i_virtual_address),
        .o_result_valid   (o_result_valid),
        .o_descriptor     (o_descriptor),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Memory word holding entry idx of the table at physical address table_pa.
    function automatic int unsigned entry_word(input logic [63:0] table_pa,
                                               input logic [8:0] idx);
        logic [63:0] w;
        w = ((table_pa & 64'h0000_FFFF_FFFF_F000) >> 3) + 64'(idx);
        return int'(w % MEM_WORDS);
    endfunction

    function automatic logic [63:0] walk_tables(input logic [47:0] va);
        logic [63:0] d;
        logic [63:0] base;
        int lvl;
        base = {16'h0, root_base};
        for (lvl = 0; lvl < 4; lvl++) begin
            d = table_mem[entry_word(base, va[47 - 9*lvl -: 9])];
            if ((lvl == 1 || lvl == 2) && d[1:0] == KIND_BLOCK) return d;
            if (d[1:0] != KIND_TABLE) return 64'h0;
            if (lvl == 3) return d;
            base = d;
        end
        return 64'h0;
    endfunction

    // Driver and predictor: the model is updated at the edge of each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            for (int i = 0; i < MEM_WORDS; i++) table_mem[i] = 64'h0;
            root_base = '0;
        end else begin
            if (start && !busy) begin
                if (i_command == CMD_WRITE) begin
                    table_mem[i_word_index] = i_word_value;
                end else begin
                    descriptors_due.push_back(walk_tables(i_virtual_address));
                end
                items_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) root_base = i_cfg_data;
            if (!start || !busy) begin
                if (command_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    next_cmd = command_queue.pop_front();
                    start <= 1'b1;
                    i_command <= next_cmd.translate;
                    i_word_index <= next_cmd.word_index;
                    i_word_value <= next_cmd.word_value;
                    i_virtual_address <= next_cmd.virtual_address;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Result monitor: the receiver cannot stall, so every strobe is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (descriptors_due.size() == 0) begin
                $display("%0t: unexpected descriptor, expected none, got %h",
                         $time, o_descriptor);
                mismatches++;
            end else begin
                want = descriptors_due.pop_front();
                translations++;
                if (want == 64'h0) faults++;
                else hits++;
                if (o_descriptor !== want) begin
                    $display("%0t: descriptor mismatch, expected %h, got %h",
                             $time, want, o_descriptor);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("four_level_page_table_walker_test failed");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input logic [11:0] idx,
                             input logic [63:0] value, input logic [47:0] va);
        t_item it;
        it.translate = cmd;
        it.word_index = idx;
        it.word_value = value;
        it.virtual_address = va;
        command_queue.push_back(it);
        items_queued++;
    endtask

    // Wait until every command has been transferred and every result checked,
    // then leave time for trailing writes to retire.
    task automatic wait_idle;
        while (items_accepted != items_queued || descriptors_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_root(input logic [47:0] base);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= base;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes a chain of table entries for a random address, ending in a block,
    // a page or a fault at a random level, then translates that address and
    // up to two neighbors.
    task automatic queue_walk(input logic [2:0] root_slot);
        logic [47:0] va;
        logic [47:0] probe;
        logic [2:0]  slot;
        logic [2:0]  next_slot;
        logic [63:0] d;
        int depth;
        int lvl;
        int n;
        va = 48'({$urandom, $urandom});
        depth = $urandom_range(3, 0);
        slot = root_slot;
        for (lvl = 0; lvl <= depth; lvl++) begin
            next_slot = 3'($urandom_range(7, 0));
            d = {$urandom, $urandom};
            d[14:12] = next_slot;
            if (lvl < depth) d[1:0] = KIND_TABLE;
            else if (lvl == 3) d[1:0] = ($urandom_range(9, 0) < 7) ? KIND_TABLE
                                                                  : 2'($urandom_range(2, 0));
            else if (lvl > 0) d[1:0] = ($urandom_range(9, 0) < 6) ? KIND_BLOCK
                                                                 : 2'($urandom_range(3, 0));
            else d[1:0] = 2'($urandom_range(2, 0));
            push_item(CMD_WRITE, {slot, va[47 - 9*lvl -: 9]}, d, '0);
            slot = next_slot;
        end
        n = $urandom_range(3, 1);
        for (int k = 0; k < n; k++) begin
            probe = va;
            if (k > 0) begin
                if ($urandom_range(1, 0) == 1) probe[11:0] = 12'($urandom);
                else probe[$urandom_range(47, 0)] ^= 1'b1;
            end
            push_item(CMD_TRANSLATE, 12'($urandom), {$urandom, $urandom}, probe);
        end
    endtask

    task automatic queue_random(input int count, input logic [2:0] root_slot);
        int first;
        int r;
        first = items_queued;
        while (items_queued - first < count) begin
            r = $urandom_range(99, 0);
            if (r < 75) queue_walk(root_slot);
            else if (r < 88) push_item(CMD_WRITE, 12'($urandom), {$urandom, $urandom}, '0);
            else push_item(CMD_TRANSLATE, 12'($urandom), {$urandom, $urandom},
                           48'({$urandom, $urandom}));
        end
    endtask

    initial begin
        logic [47:0] base;
        int idle_plan [3];
        idle_plan = '{28, 80, 0};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_root(48'h0);

        // Directed: empty memory, block/page/fault outcomes across the levels, and
        // the all-ones corner where every index selects the last entry.
        push_item(CMD_TRANSLATE, 12'h000, 64'h0, 48'h0);
        push_item(CMD_TRANSLATE, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        push_item(CMD_WRITE, 12'd0, 64'hFFFF_FFFF_FFFF_9003, '0);
        push_item(CMD_WRITE, 12'd512, 64'h0000_0000_4000_0001, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0000_0000_0ABC);
        push_item(CMD_WRITE, 12'd512, 64'h0000_0000_0000_0002, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        push_item(CMD_WRITE, 12'd512, 64'h8000_0000_0000_2003, '0);
        push_item(CMD_WRITE, 12'd1024, 64'h0000_0000_0020_0001, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        push_item(CMD_WRITE, 12'd1024, 64'h0000_0000_0000_3003, '0);
        push_item(CMD_WRITE, 12'd1536, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        push_item(CMD_WRITE, 12'd1536, 64'h0000_0000_0000_0001, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        push_item(CMD_WRITE, 12'd1536, 64'h0000_0000_0000_0002, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        push_item(CMD_WRITE, 12'd511, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        push_item(CMD_WRITE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFF, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'hFFFF_FFFF_FFFF);
        push_item(CMD_WRITE, 12'd4095, 64'hFFFF_FFFF_FFFF_FFFD, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'hFFFF_FFFF_FFFF);
        push_item(CMD_WRITE, 12'd511, 64'hFFFF_FFFF_FFFF_FFFD, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'hFFFF_FFFF_FFFF);
        push_item(CMD_WRITE, 12'd0, 64'h0, '0);
        push_item(CMD_TRANSLATE, 12'h0, 64'h0, 48'h0);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 0) base = 48'hFFFF_FFFF_FFFF;
            else base = 48'({$urandom, $urandom});
            write_root(base);
            @(posedge i_clk);
            sender_idle_pct <= idle_plan[ph];
            // The first half drains completely before the second is queued.
            queue_random(PHASE_ITEMS / 2, base[14:12]);
            wait_idle();
            queue_random(PHASE_ITEMS / 2, base[14:12]);
            wait_idle();
        end

        $display("Ran %0d commands over four root table settings and three pacing modes.",
                 items_accepted);
        $display("Checked %0d translations: %0d descriptors returned, %0d faults.",
                 translations, hits, faults);
        if (mismatches == 0) begin
            $display("four_level_page_table_walker_test passed");
        end else begin
            $display("four_level_page_table_walker_test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/pwt_pkg.sv
sv/pwt_ram.sv
sv/pwt_front.sv
sv/pwt_back.sv
sv/four_level_page_table_walker.sv
tb/sv/four_level_page_table_walker_test.sv
